// ===== rtl/chv_pkg.sv =====
// Shared types, constants and character-class functions for the cookie header validator.
// Depends on nothing; used by rtl/cookie_header_validator.sv.

package chv_pkg;

    // Counter and register widths
    localparam int LEN_BITS   = 16;
    localparam int TEXT_BITS  = 17;
    localparam int PAIR_BITS  = 16;
    localparam int CFG_BITS   = 16;
    localparam int BYTE_BITS  = 8;
    localparam int CIDX_BITS  = 2;
    localparam int STAT_BITS  = 2;
    localparam int OUT_BITS   = 24;

    typedef logic [LEN_BITS-1:0]  len_t;
    typedef logic [TEXT_BITS-1:0] text_len_t;
    typedef logic [PAIR_BITS-1:0] pair_cnt_t;
    typedef logic [CFG_BITS-1:0]  cfg_val_t;
    typedef logic [BYTE_BITS-1:0] byte_t;
    typedef logic [CIDX_BITS-1:0] cfg_idx_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_MAX_TOTAL = 2'd0;
    localparam cfg_idx_t REG_MAX_PAIRS = 2'd1;
    localparam cfg_idx_t REG_MAX_NAME  = 2'd2;
    localparam cfg_idx_t REG_MAX_VALUE = 2'd3;

    // Parse phase, one-hot
    typedef enum logic [3:0] {
        PH_LEAD  = 4'b0001,  // blanks before a name
        PH_NAME  = 4'b0010,  // inside the name
        PH_VLEAD = 4'b0100,  // after '=', before the first value byte
        PH_VALUE = 4'b1000   // inside the value
    } phase_t;

    // Sticky error code of the text under way
    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_SYNTAX     = 2'd1,
        ERR_LIMIT      = 2'd2,
        ERR_LIMIT_SEMI = 2'd3   // limit hit on a pair closed by ';', pending trailing check
    } err_t;

    // Result status codes
    typedef enum logic [STAT_BITS-1:0] {
        ST_VALID  = 2'd0,
        ST_SYNTAX = 2'd1,
        ST_LIMIT  = 2'd2,
        ST_RSVD   = 2'd3
    } status_t;

    // Characters
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_SEMI  = 8'h3B;
    localparam byte_t CH_EQ    = 8'h3D;
    localparam byte_t CH_QUOTE = 8'h22;

    function automatic logic is_blank(input byte_t c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // Cookie-octet: printable ASCII without blank, quote, comma, semicolon, backslash
    function automatic logic is_octet(input byte_t c);
        return (c == 8'h21) ||
               (c >= 8'h23 && c <= 8'h2B) ||
               (c >= 8'h2D && c <= 8'h3A) ||
               (c >= 8'h3C && c <= 8'h5B) ||
               (c >= 8'h5D && c <= 8'h7E);
    endfunction

    // HTTP token character
    function automatic logic is_tchar(input byte_t c);
        logic alnum;
        logic punct;
        alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h41 && c <= 8'h5A);
        punct = (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25) ||
                (c == 8'h26) || (c == 8'h27) || (c == 8'h2A) || (c == 8'h2B) ||
                (c == 8'h2D) || (c == 8'h2E) || (c == 8'h5E) || (c == 8'h5F) ||
                (c == 8'h60) || (c == 8'h7C) || (c == 8'h7E);
        return alnum || punct;
    endfunction

endpackage

// ===== rtl/cookie_header_validator.sv =====
// Top level of the cookie header validator: input register, per-byte parser, result register.
// Depends on rtl/chv_pkg.sv.

// Streams the bytes of a Cookie header value one item per clock, save for the tlast stall below,
// and gives one verdict item (status and pair count) on the item that carries tlast. Each item
// takes the single parser update between the input register and the result register; an
// accepted tlast item passes through both registers in that order. Input items are taken while
// a result still waits, except that a tlast item holds in the input register until the result
// register is free. An item with tuser low and tlast low is ignored. Limits must be written
// on the cfg port only while no text is in flight (not enforced here); 0 disables a limit.

module cookie_header_validator (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_text
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] status, [17:2] pair_count, [23:18] zero
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers
    chv_pkg::cfg_val_t max_total_reg;
    chv_pkg::cfg_val_t max_pairs_reg;
    chv_pkg::cfg_val_t max_name_reg;
    chv_pkg::cfg_val_t max_value_reg;

    // Input register
    logic               in_valid_reg;
    chv_pkg::byte_t     in_byte_reg;
    logic               in_has_reg;
    logic               in_eot_reg;

    // Parser state
    chv_pkg::phase_t    phase_reg, phase_next;
    chv_pkg::len_t      name_len_reg, name_len_next;
    chv_pkg::len_t      value_len_reg, value_len_next;
    logic               pend_blank_reg, pend_blank_next;
    logic               open_quote_reg, open_quote_next;
    logic               last_quote_reg, last_quote_next;
    chv_pkg::text_len_t text_len_reg, text_len_next;
    chv_pkg::pair_cnt_t pairs_reg, pairs_next;
    chv_pkg::err_t      err_reg, err_next;

    // Result register
    logic               m_valid_reg;
    chv_pkg::status_t   m_status_reg;
    chv_pkg::pair_cnt_t m_pairs_reg;

    // Working values of the parser update
    logic               consume;
    logic               close_semi;
    logic               do_close;
    chv_pkg::status_t   status_c;
    chv_pkg::pair_cnt_t res_pairs_c;

    // Move the held item through the parser unless it needs a busy result register
    assign consume   = in_valid_reg && (!in_eot_reg || !m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || consume;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_pairs_reg, m_status_reg};

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_total_reg <= '0;
            max_pairs_reg <= '0;
            max_name_reg  <= '0;
            max_value_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                chv_pkg::REG_MAX_TOTAL: max_total_reg <= cfg_data;
                chv_pkg::REG_MAX_PAIRS: max_pairs_reg <= cfg_data;
                chv_pkg::REG_MAX_NAME:  max_name_reg  <= cfg_data;
                chv_pkg::REG_MAX_VALUE: max_value_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture an item into the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_has_reg  <= s_tuser[0];
            in_eot_reg  <= s_tlast;
        end
    end

    // Parser update for one item
    always_comb begin
        phase_next      = phase_reg;
        name_len_next   = name_len_reg;
        value_len_next  = value_len_reg;
        pend_blank_next = pend_blank_reg;
        open_quote_next = open_quote_reg;
        last_quote_next = last_quote_reg;
        text_len_next   = text_len_reg;
        pairs_next      = pairs_reg;
        err_next        = err_reg;
        close_semi      = 1'b0;
        do_close        = 1'b0;
        status_c        = chv_pkg::ST_VALID;
        res_pairs_c     = '0;

        // Take the byte
        if (in_has_reg) begin
            if (text_len_next != '1) begin
                text_len_next = text_len_next + chv_pkg::text_len_t'(1);
            end
            if (chv_pkg::is_blank(in_byte_reg)) begin
                if (phase_next == chv_pkg::PH_NAME || phase_next == chv_pkg::PH_VALUE) begin
                    pend_blank_next = 1'b1;
                end
            end else begin
                // a limit error stays a limit error once a new pair starts
                if (phase_next == chv_pkg::PH_LEAD && err_next == chv_pkg::ERR_LIMIT_SEMI) begin
                    err_next = chv_pkg::ERR_LIMIT;
                end
                if (in_byte_reg == chv_pkg::CH_SEMI) begin
                    if (phase_next == chv_pkg::PH_LEAD) begin
                        if (err_next == chv_pkg::ERR_NONE) err_next = chv_pkg::ERR_SYNTAX;
                    end else if (phase_next == chv_pkg::PH_NAME) begin
                        if (err_next == chv_pkg::ERR_NONE) err_next = chv_pkg::ERR_SYNTAX;
                        name_len_next   = '0;
                        value_len_next  = '0;
                        pend_blank_next = 1'b0;
                        open_quote_next = 1'b0;
                        last_quote_next = 1'b0;
                        phase_next      = chv_pkg::PH_LEAD;
                    end else begin
                        close_semi = 1'b1;
                    end
                end else if (phase_next == chv_pkg::PH_LEAD &&
                             in_byte_reg == chv_pkg::CH_EQ) begin
                    // empty name
                    if (err_next == chv_pkg::ERR_NONE) err_next = chv_pkg::ERR_SYNTAX;
                    phase_next = chv_pkg::PH_VLEAD;
                end else if (phase_next == chv_pkg::PH_NAME &&
                             in_byte_reg == chv_pkg::CH_EQ) begin
                    pend_blank_next = 1'b0;
                    phase_next      = chv_pkg::PH_VLEAD;
                end else if (phase_next == chv_pkg::PH_LEAD ||
                             phase_next == chv_pkg::PH_NAME) begin
                    // name byte
                    phase_next = chv_pkg::PH_NAME;
                    if (pend_blank_next || !chv_pkg::is_tchar(in_byte_reg)) begin
                        if (err_next == chv_pkg::ERR_NONE) err_next = chv_pkg::ERR_SYNTAX;
                    end
                    if (name_len_next != '1) begin
                        name_len_next = name_len_next + chv_pkg::len_t'(1);
                    end
                end else begin
                    // value byte
                    phase_next = chv_pkg::PH_VALUE;
                    if (pend_blank_next && err_next == chv_pkg::ERR_NONE) begin
                        err_next = chv_pkg::ERR_SYNTAX;
                    end
                    if (value_len_next == '0) begin
                        open_quote_next = (in_byte_reg == chv_pkg::CH_QUOTE);
                        if (!open_quote_next && !chv_pkg::is_octet(in_byte_reg) &&
                            err_next == chv_pkg::ERR_NONE) begin
                            err_next = chv_pkg::ERR_SYNTAX;
                        end
                    end else begin
                        if ((last_quote_next || (in_byte_reg != chv_pkg::CH_QUOTE &&
                             !chv_pkg::is_octet(in_byte_reg))) &&
                            err_next == chv_pkg::ERR_NONE) begin
                            err_next = chv_pkg::ERR_SYNTAX;
                        end
                        last_quote_next = (in_byte_reg == chv_pkg::CH_QUOTE);
                    end
                    if (value_len_next != '1) begin
                        value_len_next = value_len_next + chv_pkg::len_t'(1);
                    end
                end
            end
        end

        // Close a pair on ';' or at the end of the text
        do_close = close_semi || (in_eot_reg && (phase_next == chv_pkg::PH_VLEAD ||
                                                 phase_next == chv_pkg::PH_VALUE));
        if (do_close) begin
            if (open_quote_next != last_quote_next && err_next == chv_pkg::ERR_NONE) begin
                err_next = chv_pkg::ERR_SYNTAX;
            end
            if (err_next == chv_pkg::ERR_NONE &&
                ((max_pairs_reg != '0 && pairs_next >= max_pairs_reg) ||
                 (max_name_reg != '0 && name_len_next > max_name_reg) ||
                 (max_value_reg != '0 && value_len_next > max_value_reg))) begin
                err_next = close_semi ? chv_pkg::ERR_LIMIT_SEMI : chv_pkg::ERR_LIMIT;
            end
            if (pairs_next != '1) begin
                pairs_next = pairs_next + chv_pkg::pair_cnt_t'(1);
            end
            name_len_next   = '0;
            value_len_next  = '0;
            pend_blank_next = 1'b0;
            open_quote_next = 1'b0;
            last_quote_next = 1'b0;
            phase_next      = chv_pkg::PH_LEAD;
        end
        if (in_eot_reg && (close_semi || !do_close)) begin
            // blank-only text, trailing ';' or unfinished name
            if (phase_next == chv_pkg::PH_LEAD) begin
                if (text_len_next != '0 && (err_next == chv_pkg::ERR_NONE ||
                                            err_next == chv_pkg::ERR_LIMIT_SEMI)) begin
                    err_next = chv_pkg::ERR_SYNTAX;
                end
            end else if (err_next == chv_pkg::ERR_NONE) begin
                err_next = chv_pkg::ERR_SYNTAX;
            end
        end

        // Verdict
        if (max_total_reg != '0 && text_len_next > {1'b0, max_total_reg}) begin
            status_c = chv_pkg::ST_LIMIT;
        end else begin
            unique case (err_next)
                chv_pkg::ERR_NONE:       status_c = chv_pkg::ST_VALID;
                chv_pkg::ERR_SYNTAX:     status_c = chv_pkg::ST_SYNTAX;
                chv_pkg::ERR_LIMIT:      status_c = chv_pkg::ST_LIMIT;
                chv_pkg::ERR_LIMIT_SEMI: status_c = chv_pkg::ST_SYNTAX;
                default:                 status_c = chv_pkg::ST_SYNTAX;
            endcase
        end
        res_pairs_c = (status_c == chv_pkg::ST_VALID) ? pairs_next : '0;

        // Start over after the verdict
        if (in_eot_reg) begin
            name_len_next   = '0;
            value_len_next  = '0;
            pend_blank_next = 1'b0;
            open_quote_next = 1'b0;
            last_quote_next = 1'b0;
            phase_next      = chv_pkg::PH_LEAD;
            text_len_next   = '0;
            pairs_next      = '0;
            err_next        = chv_pkg::ERR_NONE;
        end
    end

    // Advance parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= chv_pkg::PH_LEAD;
            name_len_reg   <= '0;
            value_len_reg  <= '0;
            pend_blank_reg <= 1'b0;
            open_quote_reg <= 1'b0;
            last_quote_reg <= 1'b0;
            text_len_reg   <= '0;
            pairs_reg      <= '0;
            err_reg        <= chv_pkg::ERR_NONE;
        end else if (consume) begin
            phase_reg      <= phase_next;
            name_len_reg   <= name_len_next;
            value_len_reg  <= value_len_next;
            pend_blank_reg <= pend_blank_next;
            open_quote_reg <= open_quote_next;
            last_quote_reg <= last_quote_next;
            text_len_reg   <= text_len_next;
            pairs_reg      <= pairs_next;
            err_reg        <= err_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (consume && in_eot_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_eot_reg) begin
            m_status_reg <= status_c;
            m_pairs_reg  <= res_pairs_c;
        end
    end

    // Parser state is cleared after every verdict
    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_eot_reg |=> text_len_reg == '0 && pairs_reg == '0 &&
                                  err_reg == chv_pkg::ERR_NONE)
        else $error("parser state not cleared after result");

    // Pending semicolon limit error only exists between pairs
    a_semi_err_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg == chv_pkg::ERR_LIMIT_SEMI |-> phase_reg == chv_pkg::PH_LEAD)
        else $error("pending limit error outside leading phase");

    // A failed text reports no pairs
    a_fail_no_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != chv_pkg::ST_VALID |-> m_pairs_reg == '0)
        else $error("pair count reported on failed text");

    // A held result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !(consume && in_eot_reg))
        else $error("result overwritten while stalled");

endmodule
